// ----- rtl/lwfs_pkg.sv -----
`default_nettype none

package lwfs_pkg;

    // Link byte sequence positions
    typedef enum logic [3:0] {
        PH_COL_CMD    = 4'd0,
        PH_COL_LO_HI  = 4'd1,
        PH_COL_LO_LO  = 4'd2,
        PH_COL_HI_HI  = 4'd3,
        PH_COL_HI_LO  = 4'd4,
        PH_PAGE_CMD   = 4'd5,
        PH_PAGE_LO_HI = 4'd6,
        PH_PAGE_LO_LO = 4'd7,
        PH_PAGE_HI_HI = 4'd8,
        PH_PAGE_HI_LO = 4'd9,
        PH_MEM_CMD    = 4'd10,
        PH_COLOR      = 4'd11
    } phase_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_COLUMN_OPCODE = 2'd0,
        REG_PAGE_OPCODE   = 2'd1,
        REG_MEMWR_OPCODE  = 2'd2
    } reg_index_t;

    localparam logic [7:0] COLUMN_OPCODE_RESET = 8'd42;
    localparam logic [7:0] PAGE_OPCODE_RESET   = 8'd43;
    localparam logic [7:0] MEMWR_OPCODE_RESET  = 8'd44;

    // Input item mode
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    // Command opcodes handed to the sequencer
    typedef struct packed {
        logic [7:0] column_opcode;
        logic [7:0] page_opcode;
        logic [7:0] memwr_opcode;
    } opcodes_t;

    // One link byte result
    typedef struct packed {
        logic [7:0] link_byte;
        logic       is_command;
        logic       last_byte;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/lwfs_core.sv -----
`default_nettype none

module lwfs_core #(
    parameter int COORD_BITS = 10
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  item_valid,
    input  wire logic                  item_mode,
    input  wire logic [COORD_BITS-1:0] x_first,
    input  wire logic [COORD_BITS-1:0] y_first,
    input  wire logic [COORD_BITS-1:0] x_second,
    input  wire logic [COORD_BITS-1:0] y_second,
    input  wire logic [15:0]           fill_color,
    input  wire lwfs_pkg::opcodes_t    opcodes,
    output logic                       res_valid,
    output lwfs_pkg::result_t          res
);

    lwfs_pkg::phase_t        phase_reg, phase_next;
    logic                    busy_reg, busy_next;
    logic                    low_next_reg, low_next_next;
    logic [COORD_BITS-1:0]   col_lo_reg, col_lo_next;
    logic [COORD_BITS-1:0]   col_hi_reg, col_hi_next;
    logic [COORD_BITS-1:0]   page_lo_reg, page_lo_next;
    logic [COORD_BITS-1:0]   page_hi_reg, page_hi_next;
    logic [15:0]             color_reg, color_next;
    // Pixel countdown: x position within a row (inner), rows left (outer)
    logic [COORD_BITS-1:0]   x_span_reg, x_span_next;
    logic [COORD_BITS-1:0]   x_left_reg, x_left_next;
    logic [COORD_BITS-1:0]   y_left_reg, y_left_next;

    logic                    start;
    logic                    tick;
    logic                    x_swap;
    logic                    y_swap;
    logic [COORD_BITS-1:0]   x_lo;
    logic [COORD_BITS-1:0]   x_hi;
    logic [COORD_BITS-1:0]   y_lo;
    logic [COORD_BITS-1:0]   y_hi;
    logic [15:0]             col_lo16;
    logic [15:0]             col_hi16;
    logic [15:0]             page_lo16;
    logic [15:0]             page_hi16;
    logic                    final_byte;

    assign start = item_valid && (item_mode == lwfs_pkg::MODE_START) && !busy_reg;
    assign tick  = item_valid && (item_mode == lwfs_pkg::MODE_TICK) && busy_reg;

    // Corner ordering
    assign x_swap = x_first > x_second;
    assign y_swap = y_first > y_second;
    assign x_lo   = x_swap ? x_second : x_first;
    assign x_hi   = x_swap ? x_first  : x_second;
    assign y_lo   = y_swap ? y_second : y_first;
    assign y_hi   = y_swap ? y_first  : y_second;

    // Bounds as 16-bit words, zero upper bits
    assign col_lo16  = 16'(col_lo_reg);
    assign col_hi16  = 16'(col_hi_reg);
    assign page_lo16 = 16'(page_lo_reg);
    assign page_hi16 = 16'(page_hi_reg);

    assign final_byte = low_next_reg && (x_left_reg == '0) && (y_left_reg == '0);

    // Next state
    always_comb begin
        phase_next    = phase_reg;
        busy_next     = busy_reg;
        low_next_next = low_next_reg;
        col_lo_next   = col_lo_reg;
        col_hi_next   = col_hi_reg;
        page_lo_next  = page_lo_reg;
        page_hi_next  = page_hi_reg;
        color_next    = color_reg;
        x_span_next   = x_span_reg;
        x_left_next   = x_left_reg;
        y_left_next   = y_left_reg;
        if (start) begin
            phase_next    = lwfs_pkg::PH_COL_CMD;
            busy_next     = 1'b1;
            low_next_next = 1'b0;
            col_lo_next   = y_lo;
            col_hi_next   = y_hi;
            page_lo_next  = x_lo;
            page_hi_next  = x_hi;
            color_next    = fill_color;
            x_span_next   = x_hi - x_lo;
            x_left_next   = x_hi - x_lo;
            y_left_next   = y_hi - y_lo;
        end else if (tick) begin
            case (phase_reg)
                lwfs_pkg::PH_COL_CMD:    phase_next = lwfs_pkg::PH_COL_LO_HI;
                lwfs_pkg::PH_COL_LO_HI:  phase_next = lwfs_pkg::PH_COL_LO_LO;
                lwfs_pkg::PH_COL_LO_LO:  phase_next = lwfs_pkg::PH_COL_HI_HI;
                lwfs_pkg::PH_COL_HI_HI:  phase_next = lwfs_pkg::PH_COL_HI_LO;
                lwfs_pkg::PH_COL_HI_LO:  phase_next = lwfs_pkg::PH_PAGE_CMD;
                lwfs_pkg::PH_PAGE_CMD:   phase_next = lwfs_pkg::PH_PAGE_LO_HI;
                lwfs_pkg::PH_PAGE_LO_HI: phase_next = lwfs_pkg::PH_PAGE_LO_LO;
                lwfs_pkg::PH_PAGE_LO_LO: phase_next = lwfs_pkg::PH_PAGE_HI_HI;
                lwfs_pkg::PH_PAGE_HI_HI: phase_next = lwfs_pkg::PH_PAGE_HI_LO;
                lwfs_pkg::PH_PAGE_HI_LO: phase_next = lwfs_pkg::PH_MEM_CMD;
                lwfs_pkg::PH_MEM_CMD:    phase_next = lwfs_pkg::PH_COLOR;
                lwfs_pkg::PH_COLOR: begin
                    low_next_next = !low_next_reg;
                    if (low_next_reg) begin
                        if (final_byte) begin
                            busy_next  = 1'b0;
                            phase_next = lwfs_pkg::PH_COL_CMD;
                        end else if (x_left_reg == '0) begin
                            x_left_next = x_span_reg;
                            y_left_next = y_left_reg - 1'b1;
                        end else begin
                            x_left_next = x_left_reg - 1'b1;
                        end
                    end
                end
                default:                 phase_next = lwfs_pkg::PH_COL_CMD;
            endcase
        end
    end

    // Byte selection for the current position
    always_comb begin
        res_valid      = tick;
        res.link_byte  = 8'h00;
        res.is_command = 1'b0;
        res.last_byte  = 1'b0;
        case (phase_reg)
            lwfs_pkg::PH_COL_CMD: begin
                res.link_byte  = opcodes.column_opcode;
                res.is_command = 1'b1;
            end
            lwfs_pkg::PH_COL_LO_HI:  res.link_byte = col_lo16[15:8];
            lwfs_pkg::PH_COL_LO_LO:  res.link_byte = col_lo16[7:0];
            lwfs_pkg::PH_COL_HI_HI:  res.link_byte = col_hi16[15:8];
            lwfs_pkg::PH_COL_HI_LO:  res.link_byte = col_hi16[7:0];
            lwfs_pkg::PH_PAGE_CMD: begin
                res.link_byte  = opcodes.page_opcode;
                res.is_command = 1'b1;
            end
            lwfs_pkg::PH_PAGE_LO_HI: res.link_byte = page_lo16[15:8];
            lwfs_pkg::PH_PAGE_LO_LO: res.link_byte = page_lo16[7:0];
            lwfs_pkg::PH_PAGE_HI_HI: res.link_byte = page_hi16[15:8];
            lwfs_pkg::PH_PAGE_HI_LO: res.link_byte = page_hi16[7:0];
            lwfs_pkg::PH_MEM_CMD: begin
                res.link_byte  = opcodes.memwr_opcode;
                res.is_command = 1'b1;
            end
            lwfs_pkg::PH_COLOR: begin
                res.link_byte = low_next_reg ? color_reg[7:0] : color_reg[15:8];
                res.last_byte = final_byte;
            end
            default:                 res.link_byte = 8'h00;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= lwfs_pkg::PH_COL_CMD;
            busy_reg     <= 1'b0;
            low_next_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            busy_reg     <= busy_next;
            low_next_reg <= low_next_next;
        end
    end

    // Window payload
    always_ff @(posedge aclk) begin
        col_lo_reg  <= col_lo_next;
        col_hi_reg  <= col_hi_next;
        page_lo_reg <= page_lo_next;
        page_hi_reg <= page_hi_next;
        color_reg   <= color_next;
        x_span_reg  <= x_span_next;
        x_left_reg  <= x_left_next;
        y_left_reg  <= y_left_next;
    end

    // An idle sequencer always restarts at the column command
    assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> (phase_reg == lwfs_pkg::PH_COL_CMD))
        else $error("idle sequencer away from column command");

    // The final byte of a fill returns the sequencer to idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.last_byte) |=> !busy_reg)
        else $error("sequencer still busy after final byte");

endmodule

`default_nettype wire

// ----- rtl/lcd_window_fill_sequencer.sv -----
`default_nettype none

// A tick's link byte is registered, in the skid register if the held result is not taken.
// Throughput: one input transaction per cycle while s_tready is high; the sequencer steps
// one link byte per tick. A two-entry output (result register plus skid register) drops
// s_tready only when both hold bytes not yet taken. Configuration writes are taken every
// cycle. Reset (aresetn low, synchronous): sequencer idle, output empty, opcodes 42/43/44.
module lcd_window_fill_sequencer #(
    parameter int COORD_BITS = 10
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // s_tdata fields from bit 0: x_first, y_first, x_second, y_second, fill_color, zero pad
    input  wire logic [((4*COORD_BITS+16+7)/8)*8-1:0] s_tdata,
    // s_tuser: mode
    input  wire logic                  s_tuser,
    // Result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // m_tdata: link_byte
    output logic [7:0]                 m_tdata,
    // m_tuser: is_command
    output logic                       m_tuser,
    output logic                       m_tlast,
    // Configuration writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [7:0]            cfg_data
);

    localparam int XF_LSB = 0;
    localparam int YF_LSB = COORD_BITS;
    localparam int XS_LSB = 2 * COORD_BITS;
    localparam int YS_LSB = 3 * COORD_BITS;
    localparam int FC_LSB = 4 * COORD_BITS;

    logic [7:0]            col_op_reg;
    logic [7:0]            page_op_reg;
    logic [7:0]            memwr_op_reg;
    lwfs_pkg::opcodes_t    opcodes;

    logic                  in_accept;
    logic                  core_valid;
    lwfs_pkg::result_t     core_res;

    logic                  out_valid_reg, out_valid_next;
    lwfs_pkg::result_t     out_reg, out_next;
    logic                  skid_valid_reg, skid_valid_next;
    lwfs_pkg::result_t     skid_reg, skid_next;
    logic                  out_take;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign in_accept = s_tvalid && s_tready;

    // Opcode registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_op_reg   <= lwfs_pkg::COLUMN_OPCODE_RESET;
            page_op_reg  <= lwfs_pkg::PAGE_OPCODE_RESET;
            memwr_op_reg <= lwfs_pkg::MEMWR_OPCODE_RESET;
        end else if (cfg_valid) begin
            case (lwfs_pkg::reg_index_t'(cfg_index))
                lwfs_pkg::REG_COLUMN_OPCODE: col_op_reg   <= cfg_data;
                lwfs_pkg::REG_PAGE_OPCODE:   page_op_reg  <= cfg_data;
                lwfs_pkg::REG_MEMWR_OPCODE:  memwr_op_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign opcodes.column_opcode = col_op_reg;
    assign opcodes.page_opcode   = page_op_reg;
    assign opcodes.memwr_opcode  = memwr_op_reg;

    lwfs_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (in_accept),
        .item_mode  (s_tuser),
        .x_first    (s_tdata[XF_LSB +: COORD_BITS]),
        .y_first    (s_tdata[YF_LSB +: COORD_BITS]),
        .x_second   (s_tdata[XS_LSB +: COORD_BITS]),
        .y_second   (s_tdata[YS_LSB +: COORD_BITS]),
        .fill_color (s_tdata[FC_LSB +: 16]),
        .opcodes    (opcodes),
        .res_valid  (core_valid),
        .res        (core_res)
    );

    // Result register with skid stage
    assign out_take = out_valid_reg && m_tready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg) begin
            if (out_take) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (core_valid) begin
            if (!out_valid_reg || out_take) begin
                out_valid_next = 1'b1;
                out_next       = core_res;
            end else begin
                skid_valid_next = 1'b1;
                skid_next       = core_res;
            end
        end else if (out_take) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.link_byte;
    assign m_tuser  = out_reg.is_command;
    assign m_tlast  = out_reg.last_byte;

    // The skid stage only fills behind a held result
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry without result entry");

    // The final byte of a fill is always a data byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> !m_tuser)
        else $error("final byte tagged as command");

endmodule

`default_nettype wire

// ----- verif/tb_lcd_window_fill_sequencer.sv -----
`default_nettype none

module tb_lcd_window_fill_sequencer;

    localparam int          COORD_BITS  = 10;
    localparam int          TDATA_BITS  = ((4*COORD_BITS+16+7)/8)*8;
    localparam int          CYCLE_LIMIT = 300000;
    localparam int          MAX_REPORTS = 10;
    // Index past the register list; the block must drop the write
    localparam logic [1:0]  REG_UNMAPPED = 2'd3;

    // One input transaction before packing
    typedef struct {
        logic                  mode;
        logic [COORD_BITS-1:0] x_first;
        logic [COORD_BITS-1:0] y_first;
        logic [COORD_BITS-1:0] x_second;
        logic [COORD_BITS-1:0] y_second;
        logic [15:0]           fill_color;
    } fill_item_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [TDATA_BITS-1:0] s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [1:0]            cfg_index = '0;
    logic [7:0]            cfg_data  = '0;

    lcd_window_fill_sequencer #(
        .COORD_BITS(COORD_BITS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Stimulus and expectation stores
    fill_item_t           fill_items_pending[$];
    fill_item_t           item_on_bus;
    lwfs_pkg::result_t    link_bytes_due[$];
    int unsigned items_driven    = 0;
    int unsigned items_accepted  = 0;
    int unsigned cfg_writes_seen = 0;
    int unsigned cycle_count     = 0;
    int          send_idle_pct   = 0;
    int          recv_idle_pct   = 0;

    // Run statistics
    int unsigned failures       = 0;
    int unsigned bytes_checked  = 0;
    int unsigned fills_started  = 0;
    int unsigned single_pixels  = 0;
    int unsigned starts_ignored = 0;
    int unsigned idle_ticks     = 0;

    // Shadow of the sequencer: opcodes, window and progress
    logic [7:0]            col_opcode   = lwfs_pkg::COLUMN_OPCODE_RESET;
    logic [7:0]            page_opcode  = lwfs_pkg::PAGE_OPCODE_RESET;
    logic [7:0]            memwr_opcode = lwfs_pkg::MEMWR_OPCODE_RESET;
    logic                  fill_busy    = 1'b0;
    lwfs_pkg::phase_t      fill_phase   = lwfs_pkg::PH_COL_CMD;
    logic [COORD_BITS-1:0] col_lo       = '0;
    logic [COORD_BITS-1:0] col_hi       = '0;
    logic [COORD_BITS-1:0] page_lo      = '0;
    logic [COORD_BITS-1:0] page_hi      = '0;
    logic [15:0]           held_color   = '0;
    logic [20:0]           pixels_left  = '0;
    logic                  color_low_next = 1'b0;

    // Clock
    initial begin
        forever #1 aclk = ~aclk;
    end

    // One byte of a bound sent as a big-endian 16-bit word
    function automatic logic [7:0] bound_byte(logic [COORD_BITS-1:0] bound, logic upper);
        logic [15:0] word;
        word = 16'(bound);
        return upper ? word[15:8] : word[7:0];
    endfunction

    // Advance the shadow sequencer by one accepted transaction
    task automatic step_fill_sequencer(input fill_item_t it);
        lwfs_pkg::result_t res;
        if (it.mode == lwfs_pkg::MODE_START) begin
            if (fill_busy) begin
                starts_ignored++;
            end else begin
                page_lo    = (it.x_first <= it.x_second) ? it.x_first : it.x_second;
                page_hi    = (it.x_first <= it.x_second) ? it.x_second : it.x_first;
                col_lo     = (it.y_first <= it.y_second) ? it.y_first : it.y_second;
                col_hi     = (it.y_first <= it.y_second) ? it.y_second : it.y_first;
                held_color = it.fill_color;
                pixels_left = 21'(int'(page_hi) - int'(page_lo) + 1) *
                              21'(int'(col_hi) - int'(col_lo) + 1);
                fill_phase     = lwfs_pkg::PH_COL_CMD;
                color_low_next = 1'b0;
                fill_busy      = 1'b1;
                fills_started++;
                if (pixels_left == 21'd1) single_pixels++;
            end
        end else if (!fill_busy) begin
            idle_ticks++;
        end else begin
            res.is_command = 1'b0;
            res.last_byte  = 1'b0;
            case (fill_phase)
                lwfs_pkg::PH_COL_CMD: begin
                    res.link_byte  = col_opcode;
                    res.is_command = 1'b1;
                end
                lwfs_pkg::PH_COL_LO_HI:  res.link_byte = bound_byte(col_lo, 1'b1);
                lwfs_pkg::PH_COL_LO_LO:  res.link_byte = bound_byte(col_lo, 1'b0);
                lwfs_pkg::PH_COL_HI_HI:  res.link_byte = bound_byte(col_hi, 1'b1);
                lwfs_pkg::PH_COL_HI_LO:  res.link_byte = bound_byte(col_hi, 1'b0);
                lwfs_pkg::PH_PAGE_CMD: begin
                    res.link_byte  = page_opcode;
                    res.is_command = 1'b1;
                end
                lwfs_pkg::PH_PAGE_LO_HI: res.link_byte = bound_byte(page_lo, 1'b1);
                lwfs_pkg::PH_PAGE_LO_LO: res.link_byte = bound_byte(page_lo, 1'b0);
                lwfs_pkg::PH_PAGE_HI_HI: res.link_byte = bound_byte(page_hi, 1'b1);
                lwfs_pkg::PH_PAGE_HI_LO: res.link_byte = bound_byte(page_hi, 1'b0);
                lwfs_pkg::PH_MEM_CMD: begin
                    res.link_byte  = memwr_opcode;
                    res.is_command = 1'b1;
                end
                default: begin
                    // Color bytes: high then low, pixel count drops after the low byte
                    if (!color_low_next) begin
                        res.link_byte  = held_color[15:8];
                        color_low_next = 1'b1;
                    end else begin
                        res.link_byte  = held_color[7:0];
                        color_low_next = 1'b0;
                        if (pixels_left != 0) pixels_left--;
                        if (pixels_left == 0) begin
                            res.last_byte = 1'b1;
                            fill_busy     = 1'b0;
                            fill_phase    = lwfs_pkg::PH_COL_CMD;
                        end
                    end
                end
            endcase
            // Command and bound bytes step forward; memory-write lands in the color phase
            if (fill_busy && fill_phase != lwfs_pkg::PH_COLOR)
                fill_phase = lwfs_pkg::phase_t'(fill_phase + 4'd1);
            link_bytes_due.push_back(res);
        end
    endtask

    // Input acceptance and prediction
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            step_fill_sequencer(item_on_bus);
            items_accepted++;
        end
    end

    // Register write acceptance
    always @(posedge aclk) begin
        if (aresetn && cfg_valid && cfg_ready) begin
            case (cfg_index)
                lwfs_pkg::REG_COLUMN_OPCODE: col_opcode   = cfg_data;
                lwfs_pkg::REG_PAGE_OPCODE:   page_opcode  = cfg_data;
                lwfs_pkg::REG_MEMWR_OPCODE:  memwr_opcode = cfg_data;
                default: ;
            endcase
            cfg_writes_seen++;
        end
    end

    // Input driver
    always @(negedge aclk) begin
        if (!s_tvalid || items_accepted == items_driven) begin
            if (fill_items_pending.size() != 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                item_on_bus = fill_items_pending.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= item_on_bus.mode;
                // x_first, y_first, x_second, y_second, fill_color from bit 0
                s_tdata  <= TDATA_BITS'({item_on_bus.fill_color, item_on_bus.y_second,
                                         item_on_bus.x_second, item_on_bus.y_first,
                                         item_on_bus.x_first});
                items_driven++;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result backpressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic report_failure(input string msg);
        failures++;
        if (failures <= MAX_REPORTS) $display("ERROR @%0d: %s", cycle_count, msg);
    endtask

    // Result monitor
    always @(posedge aclk) begin
        lwfs_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (link_bytes_due.size() == 0) begin
                report_failure($sformatf("unexpected byte %02h cmd=%0b last=%0b",
                                         m_tdata, m_tuser, m_tlast));
            end else begin
                want = link_bytes_due.pop_front();
                bytes_checked++;
                if (m_tdata !== want.link_byte || m_tuser !== want.is_command ||
                    m_tlast !== want.last_byte) begin
                    report_failure($sformatf(
                        "byte %0d: expected %02h cmd=%0b last=%0b, got %02h cmd=%0b last=%0b",
                        bytes_checked, want.link_byte, want.is_command, want.last_byte,
                        m_tdata, m_tuser, m_tlast));
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes still due",
                     cycle_count, link_bytes_due.size());
            $display("tb_lcd_window_fill_sequencer: FAIL");
            $finish;
        end
    end

    task automatic push_item(input logic mode, input int xa, input int ya,
                             input int xb, input int yb, input int color);
        fill_item_t it;
        it.mode       = mode;
        it.x_first    = COORD_BITS'(xa);
        it.y_first    = COORD_BITS'(ya);
        it.x_second   = COORD_BITS'(xb);
        it.y_second   = COORD_BITS'(yb);
        it.fill_color = 16'(color);
        fill_items_pending.push_back(it);
    endtask

    task automatic push_noise();
        push_item(1'($urandom_range(1)), $urandom_range(1023), $urandom_range(1023),
                  $urandom_range(1023), $urandom_range(1023), $urandom_range(65535));
    endtask

    // Random part: mostly complete fills of small windows, some broken runs and noise
    task automatic queue_random_fills(input int quota);
        int made;
        int span_x, span_y, x0, y0, ticks, k;
        made = 0;
        while (made < quota) begin
            if ($urandom_range(99) < 80) begin
                span_x = $urandom_range(3);
                span_y = $urandom_range(3);
                x0 = $urandom_range(1023 - span_x);
                y0 = $urandom_range(1023 - span_y);
                // Corner order is random so the swap path is hit both ways
                if ($urandom_range(1))
                    push_item(lwfs_pkg::MODE_START, x0, y0 + span_y, x0 + span_x, y0,
                              $urandom);
                else
                    push_item(lwfs_pkg::MODE_START, x0 + span_x, y0, x0, y0 + span_y,
                              $urandom);
                ticks = 11 + 2 * (span_x + 1) * (span_y + 1);
                // Cut some runs short; the remainder drains into the next run
                if ($urandom_range(9) == 0) ticks = $urandom_range(1, ticks);
                for (k = 0; k < ticks; k++) begin
                    if ($urandom_range(19) == 0) begin
                        push_item(lwfs_pkg::MODE_START, $urandom_range(1023),
                                  $urandom_range(1023), $urandom_range(1023),
                                  $urandom_range(1023), $urandom);
                        made++;
                    end
                    push_item(lwfs_pkg::MODE_TICK, $urandom_range(1023), $urandom_range(1023),
                              $urandom_range(1023), $urandom_range(1023), $urandom);
                end
                made += ticks + 1;
            end else begin
                for (k = $urandom_range(1, 4); k > 0; k--) begin
                    push_noise();
                    made++;
                end
            end
        end
    endtask

    // Wait until every transaction is in and every byte is out, plus pipeline slack
    task automatic wait_drained();
        while (fill_items_pending.size() != 0 || items_accepted != items_driven ||
               link_bytes_due.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        int unsigned seen;
        seen = cfg_writes_seen;
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(negedge aclk); while (cfg_writes_seen == seen);
        cfg_valid <= 1'b0;
    endtask

    // Main sequence
    initial begin
        int k;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 9;
        recv_idle_pct = 82;

        // Directed: reset opcodes, idle tick, single pixel at the far corner,
        // start while busy, then a reversed-corner window left mid-sequence
        push_item(lwfs_pkg::MODE_TICK, 1023, 1023, 1023, 1023, 16'hFFFF);
        push_item(lwfs_pkg::MODE_START, 1023, 1023, 1023, 1023, 16'hFFFF);
        push_item(lwfs_pkg::MODE_START, 0, 0, 5, 5, 16'h1234);
        for (k = 0; k < 13; k++) push_item(lwfs_pkg::MODE_TICK, 0, 0, 0, 0, 0);
        push_item(lwfs_pkg::MODE_TICK, 0, 0, 0, 0, 0);
        push_item(lwfs_pkg::MODE_START, 1023, 513, 1022, 512, 16'h0000);
        for (k = 0; k < 7; k++) push_item(lwfs_pkg::MODE_TICK, 0, 0, 0, 0, 0);
        // Sender holds off here until every byte has come back
        wait_drained();

        for (int phase_no = 0; phase_no < 3; phase_no++) begin
            case (phase_no)
                0: begin
                    // Opcode changes land while the directed fill is still open
                    write_reg(lwfs_pkg::REG_COLUMN_OPCODE, 8'h00);
                    write_reg(lwfs_pkg::REG_PAGE_OPCODE, 8'hFF);
                    write_reg(lwfs_pkg::REG_MEMWR_OPCODE, 8'h00);
                    write_reg(REG_UNMAPPED, 8'($urandom));
                end
                1: begin
                    send_idle_pct = 82;
                    recv_idle_pct = 9;
                    write_reg(lwfs_pkg::REG_COLUMN_OPCODE, 8'hFF);
                    write_reg(lwfs_pkg::REG_PAGE_OPCODE, 8'h00);
                    write_reg(lwfs_pkg::REG_MEMWR_OPCODE, 8'hFF);
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    write_reg(lwfs_pkg::REG_COLUMN_OPCODE, 8'($urandom));
                    write_reg(lwfs_pkg::REG_PAGE_OPCODE, 8'($urandom));
                    write_reg(lwfs_pkg::REG_MEMWR_OPCODE, 8'($urandom));
                    write_reg(REG_UNMAPPED, 8'($urandom));
                end
            endcase
            queue_random_fills(120);
            wait_drained();
        end
        repeat (8) @(negedge aclk);

        $display("Covered %0d fills (%0d single-pixel), %0d starts dropped while busy,",
                 fills_started, single_pixels, starts_ignored);
        $display("%0d ticks while idle, %0d link bytes checked, %0d register writes.",
                 idle_ticks, bytes_checked, cfg_writes_seen);
        if (failures == 0 && link_bytes_due.size() == 0) begin
            $display("tb_lcd_window_fill_sequencer: PASS");
        end else begin
            $display("%0d failures, %0d bytes never arrived", failures, link_bytes_due.size());
            $display("tb_lcd_window_fill_sequencer: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/lwfs_pkg.sv
rtl/lwfs_core.sv
rtl/lcd_window_fill_sequencer.sv
verif/tb_lcd_window_fill_sequencer.sv
